[hdl/gsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsu_pkg
// Shared types and constants for the 2D GJK simplex update block.
// ----------------------------------------------------------------------------
package gsu_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int PW = 17;  // simplex point width
    localparam int DW = 55;  // direction width
    localparam int MW = 36;  // single multiply product width (max 35 + sign)

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;

    // multiplier operand selects
    typedef enum logic [3:0] {
        OP_NONE, OP_SEG_D1, OP_SEG_D2, OP_SEG_X, OP_SEG_Y,
        OP_TRI_DAB1, OP_TRI_DAB2, OP_TRI_EAC1, OP_TRI_EAC2,
        OP_TRI_EAB1, OP_TRI_EAB2, OP_TRI_X, OP_TRI_Y
    } t_mop;

    typedef struct packed {
        logic       load;      // capture input transaction
        logic       add_pt;    // append point
        logic       clear;     // empty simplex
        logic       prep;      // compute edge vectors
        t_mop       mop;       // multiply step
        logic       seg_fix;   // apply perpendicular fallback
        logic       drop_b;    // triangle: keep c, a
        logic       drop_c;    // triangle: keep b, a
        logic       set_cont;
        logic       clr_flags;
        logic       set_rej;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] size;
        logic       keep_ac;   // origin beyond edge ac
        logic       keep_ab;   // origin beyond edge ab
    } t_sts;
endpackage

[hdl/gsu_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsu_datapath
// Simplex store, edge vectors and one shared multiplier with accumulators.
// ----------------------------------------------------------------------------
module gsu_datapath import gsu_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [1:0]           i_kind,
    input  logic signed [15:0]   i_first_x,
    input  logic signed [15:0]   i_first_y,
    input  logic signed [15:0]   i_second_x,
    input  logic signed [15:0]   i_second_y,
    output logic [1:0]           o_point_count,
    output logic signed [PW-1:0] o_last_x,
    output logic signed [PW-1:0] o_last_y,
    output logic signed [DW-1:0] o_dir_x,
    output logic signed [DW-1:0] o_dir_y,
    output logic                 o_dir_valid,
    output logic                 o_contains_origin,
    output logic                 o_add_rejected
);
    logic [1:0]           r_kind;
    logic signed [PW-1:0] r_nx, r_ny;
    logic signed [PW-1:0] r_px [3];
    logic signed [PW-1:0] r_py [3];
    logic [1:0]           r_size;
    // edge vectors (18 bits) and origin vector
    logic signed [PW:0]   r_abx, r_aby, r_acx, r_acy, r_aox, r_aoy;
    logic signed [MW:0]   r_d, r_e2;   // cross products (37 bits)
    logic signed [MW:0]   r_e1;
    logic signed [DW-1:0] r_dx, r_dy;
    logic                 r_dv, r_co, r_rj;
    logic                 r_keep_ac;

    logic signed [COORD_WIDTH-1:0] w_fx, w_fy, w_sx, w_sy;
    assign w_fx = i_first_x[COORD_WIDTH-1:0];
    assign w_fy = i_first_y[COORD_WIDTH-1:0];
    assign w_sx = i_second_x[COORD_WIDTH-1:0];
    assign w_sy = i_second_y[COORD_WIDTH-1:0];

    // shared multiplier: 37 x 19 signed, accumulate or load
    logic signed [MW:0]   m_a;
    logic signed [PW+1:0] m_b;
    logic signed [DW+1:0] m_p;
    logic                 m_acc, m_neg;
    always_comb begin
        m_a = '0; m_b = '0; m_acc = 1'b0; m_neg = 1'b0;
        unique case (i_cmd.mop)
            OP_NONE:     ;
            OP_SEG_D1:   begin m_a = (MW+1)'(r_abx); m_b = (PW+2)'(r_aoy); end
            OP_SEG_D2:   begin m_a = (MW+1)'(r_aby); m_b = (PW+2)'(r_aox);
                               m_acc = 1'b1; m_neg = 1'b1; end
            OP_SEG_X:    begin m_a = r_d; m_b = (PW+2)'(r_aby); m_neg = 1'b1; end
            OP_SEG_Y:    begin m_a = r_d; m_b = (PW+2)'(r_abx); end
            OP_TRI_DAB1: begin m_a = (MW+1)'(r_abx); m_b = (PW+2)'(r_acy); end
            OP_TRI_DAB2: begin m_a = (MW+1)'(r_aby); m_b = (PW+2)'(r_acx);
                               m_acc = 1'b1; m_neg = 1'b1; end
            OP_TRI_EAC1: begin m_a = (MW+1)'(r_aoy); m_b = (PW+2)'(r_acx); end
            OP_TRI_EAC2: begin m_a = (MW+1)'(r_aox); m_b = (PW+2)'(r_acy);
                               m_acc = 1'b1; m_neg = 1'b1; end
            OP_TRI_EAB1: begin m_a = (MW+1)'(r_aoy); m_b = (PW+2)'(r_abx); end
            OP_TRI_EAB2: begin m_a = (MW+1)'(r_aox); m_b = (PW+2)'(r_aby);
                               m_acc = 1'b1; m_neg = 1'b1; end
            OP_TRI_X:    begin m_a = r_d; m_b = (PW+2)'(r_keep_ac ? r_acy : r_aby);
                               m_neg = r_keep_ac; end
            OP_TRI_Y:    begin m_a = r_d; m_b = (PW+2)'(r_keep_ac ? r_acx : r_abx);
                               m_neg = !r_keep_ac; end
            default:     ;
        endcase
        m_p = (DW+2)'(m_a) * (DW+2)'(m_b);
    end

    logic signed [DW+1:0] w_term;
    assign w_term = m_neg ? -m_p : m_p;

    logic w_keep_ac, w_keep_ab;
    // product sign tests: dab*eac >= 0 ; (-dab)*eab >= 0
    assign w_keep_ac = (r_d == 0) || (r_e1 == 0) || (r_d[MW] == r_e1[MW]);
    assign w_keep_ab = (r_d == 0) || (r_e2 == 0) || (r_d[MW] != r_e2[MW]);

    assign o_sts = '{kind: r_kind, size: r_size, keep_ac: w_keep_ac, keep_ab: w_keep_ab};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else begin
            if (i_cmd.add_pt) r_size <= r_size + 2'd1;
            if (i_cmd.clear) r_size <= '0;
            if (i_cmd.drop_b || i_cmd.drop_c) r_size <= 2'd2;
        end
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_nx   <= PW'(w_fx) - PW'(w_sx);
            r_ny   <= PW'(w_fy) - PW'(w_sy);
        end
        if (i_cmd.add_pt) begin
            r_px[r_size] <= r_nx;
            r_py[r_size] <= r_ny;
        end
        if (i_cmd.prep) begin
            r_keep_ac <= 1'b0;
            if (r_size == 2'd2) begin
                r_abx <= (PW+1)'(r_px[0]) - (PW+1)'(r_px[1]);
                r_aby <= (PW+1)'(r_py[0]) - (PW+1)'(r_py[1]);
                r_aox <= -(PW+1)'(r_px[1]);
                r_aoy <= -(PW+1)'(r_py[1]);
            end else begin
                r_abx <= (PW+1)'(r_px[1]) - (PW+1)'(r_px[2]);
                r_aby <= (PW+1)'(r_py[1]) - (PW+1)'(r_py[2]);
                r_acx <= (PW+1)'(r_px[0]) - (PW+1)'(r_px[2]);
                r_acy <= (PW+1)'(r_py[0]) - (PW+1)'(r_py[2]);
                r_aox <= -(PW+1)'(r_px[2]);
                r_aoy <= -(PW+1)'(r_py[2]);
            end
        end
        unique case (i_cmd.mop)
            OP_SEG_D1, OP_SEG_D2, OP_TRI_DAB1, OP_TRI_DAB2:
                r_d <= m_acc ? r_d + (MW+1)'(w_term) : (MW+1)'(w_term);
            OP_TRI_EAC1, OP_TRI_EAC2:
                r_e1 <= m_acc ? r_e1 + (MW+1)'(w_term) : (MW+1)'(w_term);
            OP_TRI_EAB1, OP_TRI_EAB2:
                r_e2 <= m_acc ? r_e2 + (MW+1)'(w_term) : (MW+1)'(w_term);
            OP_SEG_X, OP_TRI_X: r_dx <= DW'(w_term);
            OP_SEG_Y, OP_TRI_Y: r_dy <= DW'(w_term);
            default: ;
        endcase
        if (i_cmd.mop == OP_TRI_EAB2) r_keep_ac <= w_keep_ac;
        if (i_cmd.seg_fix && r_dx == 0 && r_dy == 0) begin
            r_dx <= DW'(r_aby);
            r_dy <= -DW'(r_abx);
        end
        if (i_cmd.clr_flags) begin
            r_dv <= 1'b0; r_co <= 1'b0; r_rj <= 1'b0;
            r_dx <= '0; r_dy <= '0;
        end
        if (i_cmd.seg_fix) r_dv <= 1'b1;
        if (i_cmd.drop_b) begin
            r_px[1] <= r_px[2]; r_py[1] <= r_py[2]; r_dv <= 1'b1;
        end
        if (i_cmd.drop_c) begin
            r_px[0] <= r_px[1]; r_py[0] <= r_py[1];
            r_px[1] <= r_px[2]; r_py[1] <= r_py[2]; r_dv <= 1'b1;
        end
        if (i_cmd.set_cont) r_co <= 1'b1;
        if (i_cmd.set_rej)  r_rj <= 1'b1;
    end

    logic [1:0] w_li;
    assign w_li = r_size - 2'd1;
    assign o_point_count     = r_size;
    assign o_last_x          = (r_size == 2'd0) ? '0 : r_px[w_li];
    assign o_last_y          = (r_size == 2'd0) ? '0 : r_py[w_li];
    assign o_dir_x           = r_dx;
    assign o_dir_y           = r_dy;
    assign o_dir_valid       = r_dv;
    assign o_contains_origin = r_co;
    assign o_add_rejected    = r_rj;
endmodule

[hdl/gsu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsu_ctrl
// Sequencer: accepts a transaction, steps the multiplier, presents result.
// ----------------------------------------------------------------------------
module gsu_ctrl import gsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_PREP, S_SD1, S_SD2, S_SX, S_SY, S_SFIX,
        S_TD1, S_TD2, S_TE1, S_TE2, S_TF1, S_TF2, S_TDEC, S_TX, S_TY, S_OUT
    } t_state;
    t_state r_state, n_state;
    logic   r_valid, r_drop_c;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.mop = OP_NONE;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin o_cmd.load = 1'b1; n_state = S_DISP; end
            S_DISP: begin
                o_cmd.clr_flags = 1'b1;
                n_state = S_OUT;
                priority if (i_sts.kind == KIND_ADD) begin
                    if (i_sts.size == 2'd3) o_cmd.set_rej = 1'b1;
                    else o_cmd.add_pt = 1'b1;
                end else if (i_sts.kind == KIND_CLEAR) begin
                    o_cmd.clear = 1'b1;
                end else if (i_sts.kind == KIND_UPDATE && i_sts.size[1]) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin o_cmd.prep = 1'b1; n_state = (i_sts.size == 2'd2) ? S_SD1 : S_TD1; end
            S_SD1: begin o_cmd.mop = OP_SEG_D1; n_state = S_SD2; end
            S_SD2: begin o_cmd.mop = OP_SEG_D2; n_state = S_SX; end
            S_SX:  begin o_cmd.mop = OP_SEG_X;  n_state = S_SY; end
            S_SY:  begin o_cmd.mop = OP_SEG_Y;  n_state = S_SFIX; end
            S_SFIX: begin o_cmd.seg_fix = 1'b1; n_state = S_OUT; end
            S_TD1: begin o_cmd.mop = OP_TRI_DAB1; n_state = S_TD2; end
            S_TD2: begin o_cmd.mop = OP_TRI_DAB2; n_state = S_TE1; end
            S_TE1: begin o_cmd.mop = OP_TRI_EAC1; n_state = S_TE2; end
            S_TE2: begin o_cmd.mop = OP_TRI_EAC2; n_state = S_TF1; end
            S_TF1: begin o_cmd.mop = OP_TRI_EAB1; n_state = S_TF2; end
            S_TF2: begin o_cmd.mop = OP_TRI_EAB2; n_state = S_TDEC; end
            S_TDEC: begin
                priority if (i_sts.keep_ac || i_sts.keep_ab) n_state = S_TX;
                else begin o_cmd.set_cont = 1'b1; n_state = S_OUT; end
            end
            S_TX: begin o_cmd.mop = OP_TRI_X; n_state = S_TY; end
            S_TY: begin
                o_cmd.mop = OP_TRI_Y;
                o_cmd.drop_b = !r_drop_c;
                o_cmd.drop_c = r_drop_c;
                n_state = S_OUT;
            end
            S_OUT: if (!r_valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_drop_c <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_TDEC) r_drop_c <= !i_sts.keep_ac;
            if (r_valid && !i_stall) r_valid <= 1'b0;
            else if (r_state != S_OUT && n_state == S_OUT) r_valid <= 1'b1;
        end
    end
endmodule

[hdl/gjk_simplex_update_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjk_simplex_update_2d
// 2D GJK simplex keeper with segment/triangle direction update.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_stall with kind and two support points; add
// stores first - second, clear empties, update computes a new direction or reports that the origin is enclosed.
// Output channel: o_valid/i_stall carries one result transaction per input.
// One transaction at a time. Add and clear need no multiply; segment and
// triangle updates are paced by the single shared 37x19 multiplier
// stepping through the cross products. The next input is taken only
// after the result has left.
// Reset (synchronous, active low) empties the simplex and drops any pending
// result. While the receiver stalls the result holds and input stalls.
// ----------------------------------------------------------------------------
module gjk_simplex_update_2d import gsu_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_kind,
    input  logic signed [15:0]   i_first_x,
    input  logic signed [15:0]   i_first_y,
    input  logic signed [15:0]   i_second_x,
    input  logic signed [15:0]   i_second_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_point_count,
    output logic signed [PW-1:0] o_last_x,
    output logic signed [PW-1:0] o_last_y,
    output logic signed [DW-1:0] o_dir_x,
    output logic signed [DW-1:0] o_dir_y,
    output logic                 o_dir_valid,
    output logic                 o_contains_origin,
    output logic                 o_add_rejected
);
    t_cmd w_cmd;
    t_sts w_sts;

    gsu_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    gsu_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_kind, .i_first_x, .i_first_y, .i_second_x, .i_second_y,
        .o_point_count, .o_last_x, .o_last_y, .o_dir_x, .o_dir_y,
        .o_dir_valid, .o_contains_origin, .o_add_rejected
    );
endmodule

[verif/gjk_simplex_update_2d_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjk_simplex_update_2d_tb
// Self-checking bench for the 2D GJK simplex block. A local model of the
// simplex predicts every result. Directed corner cases come first, then
// random add/update sequences with noise. Idle and stall bursts are random
// on both channels, and the last part of the run has no idling.
// ----------------------------------------------------------------------------
module gjk_simplex_update_2d_tb;
    import gsu_pkg::*;

    localparam int  N_RANDOM   = 1900;
    localparam int  N_QUIET    = 40;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]    count;
        logic [PW-1:0] lx;
        logic [PW-1:0] ly;
        logic [DW-1:0] dx;
        logic [DW-1:0] dy;
        logic          dv;
        logic          co;
        logic          rj;
    } t_simplex_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_kind = KIND_CLEAR;
    logic signed [15:0]   i_first_x = '0;
    logic signed [15:0]   i_first_y = '0;
    logic signed [15:0]   i_second_x = '0;
    logic signed [15:0]   i_second_y = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [1:0]           o_point_count;
    logic signed [PW-1:0] o_last_x;
    logic signed [PW-1:0] o_last_y;
    logic signed [DW-1:0] o_dir_x;
    logic signed [DW-1:0] o_dir_y;
    logic                 o_dir_valid;
    logic                 o_contains_origin;
    logic                 o_add_rejected;

    gjk_simplex_update_2d dut (.*);

    // model state
    longint          pt_x [3];
    longint          pt_y [3];
    int unsigned     pt_count;
    t_simplex_result pending_results [$];
    int              errors;
    longint          cycles;
    bit              quiet;
    int              n_sent, n_contained, n_dirs, n_rejected;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("gjk_simplex_update_2d_tb: done, errors");
            $finish;
        end
    end

    function automatic bit same_side(longint a, longint b);
        return !((a > 0 && b < 0) || (a < 0 && b > 0));
    endfunction

    function automatic t_simplex_result predict_simplex(logic [1:0] kind,
            logic signed [15:0] fx, logic signed [15:0] fy,
            logic signed [15:0] sx, logic signed [15:0] sy);
        t_simplex_result r;
        longint ax, ay, abx, aby, acx, acy, d, dab, dac, eac, eab, dx, dy;
        r = '0;
        dx = 0;
        dy = 0;
        case (kind)
            KIND_ADD: begin
                if (pt_count >= 3) begin
                    r.rj = 1'b1;
                end else begin
                    pt_x[pt_count] = longint'(fx) - longint'(sx);
                    pt_y[pt_count] = longint'(fy) - longint'(sy);
                    pt_count++;
                end
            end
            KIND_CLEAR: pt_count = 0;
            KIND_UPDATE: begin
                if (pt_count == 2) begin
                    ax = pt_x[1]; ay = pt_y[1];
                    abx = pt_x[0] - ax; aby = pt_y[0] - ay;
                    d = abx * (-ay) - aby * (-ax);
                    dx = -d * aby;
                    dy = d * abx;
                    if (dx == 0 && dy == 0) begin
                        dx = aby;
                        dy = -abx;
                    end
                    r.dv = 1'b1;
                end else if (pt_count == 3) begin
                    ax = pt_x[2]; ay = pt_y[2];
                    abx = pt_x[1] - ax; aby = pt_y[1] - ay;
                    acx = pt_x[0] - ax; acy = pt_y[0] - ay;
                    dab = abx * acy - aby * acx;
                    dac = -dab;
                    eac = (-ay) * acx - (-ax) * acy;
                    eab = (-ay) * abx - (-ax) * aby;
                    if (same_side(dab, eac)) begin
                        dx = -dab * acy;
                        dy = dab * acx;
                        pt_x[1] = pt_x[2]; pt_y[1] = pt_y[2];
                        pt_count = 2;
                        r.dv = 1'b1;
                    end else if (same_side(dac, eab)) begin
                        dx = -dac * aby;
                        dy = dac * abx;
                        pt_x[0] = pt_x[1]; pt_y[0] = pt_y[1];
                        pt_x[1] = pt_x[2]; pt_y[1] = pt_y[2];
                        pt_count = 2;
                        r.dv = 1'b1;
                    end else begin
                        r.co = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.count = pt_count[1:0];
        if (pt_count > 0) begin
            r.lx = pt_x[pt_count-1][PW-1:0];
            r.ly = pt_y[pt_count-1][PW-1:0];
        end
        r.dx = dx[DW-1:0];
        r.dy = dy[DW-1:0];
        return r;
    endfunction

    // one input transaction; optional idle burst before it
    task automatic send_item(logic [1:0] kind, logic signed [15:0] fx,
            logic signed [15:0] fy, logic signed [15:0] sx, logic signed [15:0] sy);
        t_simplex_result r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_first_x  <= fx;
        i_first_y  <= fy;
        i_second_x <= sx;
        i_second_y <= sy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = predict_simplex(kind, fx, fy, sx, sy);
        pending_results.push_back(r);
        n_sent++;
        if (r.co) n_contained++;
        if (r.dv) n_dirs++;
        if (r.rj) n_rejected++;
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall bursts
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_simplex_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("point_count", 64'(e.count), 64'(o_point_count));
                check_field("last_x", 64'(e.lx), 64'($unsigned(o_last_x)));
                check_field("last_y", 64'(e.ly), 64'($unsigned(o_last_y)));
                check_field("dir_x", 64'(e.dx), 64'($unsigned(o_dir_x)));
                check_field("dir_y", 64'(e.dy), 64'($unsigned(o_dir_y)));
                check_field("dir_valid", 64'(e.dv), 64'(o_dir_valid));
                check_field("contains_origin", 64'(e.co), 64'(o_contains_origin));
                check_field("add_rejected", 64'(e.rj), 64'(o_add_rejected));
            end
        end
    end

    function automatic logic signed [15:0] rand_coord();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 5))
            0: return v[15:0];
            1: return v[0] ? 16'sh7fff : -16'sh8000;
            default: return 16'($signed($urandom_range(0, 80)) - 40);
        endcase
    endfunction

    task automatic send_add();
        send_item(KIND_ADD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic send_other(logic [1:0] kind);
        send_item(kind, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_directed();
        // empty, then one point: update does nothing; then a segment update
        send_other(KIND_UPDATE);
        send_item(KIND_ADD, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000);
        send_other(KIND_UPDATE);
        send_item(KIND_ADD, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff);
        send_other(KIND_UPDATE);
        send_item(KIND_ADD, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff);
        // full simplex: add rejected
        send_item(KIND_ADD, 16'sh1234, -16'sh4321, 16'sh0, 16'sh0);
        send_other(KIND_UNUSED);
        send_other(KIND_UPDATE);
        send_other(KIND_UPDATE);
        // segment through the origin: perpendicular fallback
        send_other(KIND_CLEAR);
        send_item(KIND_ADD, 16'sd1, 16'sd1, 16'sd0, 16'sd0);
        send_item(KIND_ADD, 16'sd2, 16'sd2, 16'sd0, 16'sd0);
        send_other(KIND_UPDATE);
        // triangle enclosing the origin
        send_other(KIND_CLEAR);
        send_item(KIND_ADD, -16'sd10, -16'sd10, 16'sd0, 16'sd0);
        send_item(KIND_ADD, 16'sd10, -16'sd10, 16'sd0, 16'sd0);
        send_item(KIND_ADD, 16'sd0, 16'sd10, 16'sd0, 16'sd0);
        send_other(KIND_UPDATE);
        // degenerate triangle, all points equal
        send_other(KIND_CLEAR);
        repeat (3) send_item(KIND_ADD, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
        send_other(KIND_UPDATE);
        send_other(KIND_UPDATE);
        drop_valid();
        wait_drained();
    endtask

    task automatic run_sequences(int n_items);
        int start;
        start = n_sent;
        while (n_sent - start < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise
                send_other(2'($urandom_range(0, 3)));
            end else begin
                send_other(KIND_CLEAR);
                send_add();
                if ($urandom_range(0, 3) != 0) send_add();
                send_other(KIND_UPDATE);
                repeat ($urandom_range(1, 4)) begin
                    send_add();
                    send_other(KIND_UPDATE);
                end
                if ($urandom_range(0, 7) == 0) begin
                    send_add();
                    send_add();
                end
            end
        end
    endtask

    task automatic test_random();
        run_sequences(N_RANDOM);
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        run_sequences(N_QUIET);
        drop_valid();
    endtask

    initial begin
        quiet = 1'b0;
        n_sent = 0; n_contained = 0; n_dirs = 0; n_rejected = 0;
        pt_count = 0;
        for (int k = 0; k < 3; k++) begin
            pt_x[k] = 0;
            pt_y[k] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_quiet_tail();
        wait_drained();
        repeat (30) @(posedge i_clk);
        $display("%0d transactions: %0d directions, %0d origin enclosed, %0d adds rejected",
                 n_sent, n_dirs, n_contained, n_rejected);
        if (errors == 0) begin
            $display("gjk_simplex_update_2d_tb: done, clean");
        end else begin
            $display("gjk_simplex_update_2d_tb: done, errors");
        end
        $finish;
    end
endmodule

[filelist.f]
hdl/gsu_pkg.sv
hdl/gsu_datapath.sv
hdl/gsu_ctrl.sv
hdl/gjk_simplex_update_2d.sv
verif/gjk_simplex_update_2d_tb.sv
